### rtl/pirb_pkg.sv
// ----------------------------------------------------------------------------
// pirb_pkg
// types, codes and default contents for the pmic i2c register bank
// ----------------------------------------------------------------------------
package pirb_pkg;

  // bus event codes carried by the mode field
  typedef enum logic [1:0] {
    MODE_BOUNDARY = 2'd0,  // write-start or stop
    MODE_WRITE    = 2'd1,  // byte written by the controller
    MODE_READ     = 2'd2,  // byte read by the controller
    MODE_OTHER    = 2'd3   // no effect
  } mode_t;

  localparam int RegCount  = 102;
  localparam int ChanCount = 6;  // output channels at 0x10 .. 0x60
  localparam int ChanRegs  = 6;  // registers per channel, low nibble 0 .. 5

  // addresses of the fixed registers and the general control pair
  localparam logic [7:0] Reg00Addr = 8'h00;
  localparam logic [7:0] Reg01Addr = 8'h01;
  localparam logic [7:0] Reg02Addr = 8'h02;
  localparam logic [7:0] Reg03Addr = 8'h03;

  // fixed registers and the general control pair
  localparam logic [7:0] Reg00Default = 8'hdb;
  localparam logic [7:0] Reg01Default = 8'h20;
  localparam logic [7:0] Reg02Default = 8'h54;
  localparam logic [7:0] Reg03Default = 8'hc0;
  localparam logic [7:0] Reg02Mask    = 8'hf7;

  // status address window
  localparam logic [7:0] StatFirst = 8'h04;
  localparam logic [7:0] StatLive  = 8'h05;  // first status register with live bits
  localparam logic [7:0] StatLast  = 8'h0a;
  localparam logic [7:0] LiveBits  = 8'h07;

  // per-channel write masks, channels at 0x50 and 0x60 are restricted
  localparam logic [7:0] MaskFull   = 8'hff;
  localparam logic [7:0] MaskLow    = 8'hbf;
  localparam logic [7:0] MaskSel    = 8'haf;
  localparam logic [3:0] FirstLdo   = 4'd5;

  // channel register defaults, channel by row, low nibble by column
  typedef logic [7:0] chan_default_t [ChanCount][ChanRegs];
  localparam chan_default_t ChanDefault = '{
    '{8'hf7, 8'hb7, 8'h37, 8'hf7, 8'h09, 8'hb0},
    '{8'heb, 8'hab, 8'hab, 8'heb, 8'h1d, 8'ha0},
    '{8'he3, 8'ha3, 8'h23, 8'he3, 8'h2c, 8'hb0},
    '{8'he3, 8'ha3, 8'h23, 8'he3, 8'h2c, 8'ha0},
    '{8'hb7, 8'hb7, 8'h37, 8'hb7, 8'h09, 8'ha0},
    '{8'h37, 8'h37, 8'h37, 8'h37, 8'h01, 8'ha0}
  };

  // write mask of a channel register, hi is the address high nibble
  function automatic logic [7:0] chan_mask(input logic [3:0] hi, input logic [3:0] lo);
    logic [7:0] m;
    m = MaskFull;
    if (hi >= FirstLdo) begin
      if (lo <= 4'd3) begin
        m = MaskLow;
      end else if (lo == 4'd4) begin
        m = MaskFull;
      end else begin
        m = MaskSel;
      end
    end
    return m;
  endfunction

endpackage

### rtl/pmic_i2c_register_bank.sv
// ----------------------------------------------------------------------------
// pmic_i2c_register_bank
// register bank behind an i2c power-management device
// ----------------------------------------------------------------------------
// one input channel (in_valid / in_ready) carries bus events: mode selects a
// write-start or stop, a written byte, a read byte or an ignored event, and
// write_byte holds the data of a written byte. every accepted event gives
// exactly one result transfer on the output channel (out_valid / out_ready)
// with read_byte, which is the addressed register for a read and zero else.
// the event updates the pointer, byte count and bank at the accepting edge
// and the result sits in the output register from the next cycle. throughput
// is one event per cycle while the receiver keeps up, set by the single
// output register; an event is taken whenever that register is empty or
// being emptied in the same cycle, so a stalled receiver holds the result
// and back-pressures the input without losing or repeating anything.
// synchronous reset loads the fixed default table, clears pointer and count
// and empties the output register; the bank is usable the cycle after.
// status registers 0x04 .. 0x0a reset clear and hold only sticky bits, which
// nothing in this bank sets, so a read returns the live enable bits only.
// ----------------------------------------------------------------------------
module pmic_i2c_register_bank (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [7:0] write_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_byte
);

  localparam int ChanW = $clog2(pirb_pkg::ChanCount);
  localparam int RegW  = $clog2(pirb_pkg::ChanRegs);

  // bank state
  logic [7:0] pointer;
  logic [7:0] byte_count;
  logic [7:0] reg02;
  logic [7:0] reg03;
  // one row per output channel, registers 0 .. 5 of that channel
  logic [pirb_pkg::ChanRegs-1:0][7:0] chan_row [pirb_pkg::ChanCount];

  logic            accept;
  pirb_pkg::mode_t ev;

  // pointer decode
  logic [3:0]       hi;
  logic [3:0]       lo;
  logic             in_bank;
  logic             chan_hit;
  logic [ChanW-1:0] chan_sel;
  logic [RegW-1:0]  reg_sel;
  logic [7:0]       chan_old;
  logic [7:0]       chan_m;
  logic             stat_hit;
  logic [ChanW-1:0] en_sel;
  logic [pirb_pkg::ChanCount-1:0] chan_en;
  logic [7:0]       rd_value;
  logic [7:0]       result;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign ev       = pirb_pkg::mode_t'(mode);

  assign hi       = pointer[7:4];
  assign lo       = pointer[3:0];
  assign in_bank  = pointer < 8'(pirb_pkg::RegCount);
  assign chan_hit = in_bank && (hi >= 4'd1) && (hi <= 4'(pirb_pkg::ChanCount))
                    && (lo < 4'(pirb_pkg::ChanRegs));
  assign chan_sel = ChanW'(hi - 4'd1);
  assign reg_sel  = lo[RegW-1:0];
  assign chan_old = chan_row[chan_sel][reg_sel];
  assign chan_m   = pirb_pkg::chan_mask(hi, lo);

  // enable bit 7 of each channel's first register feeds the live status bits
  always_comb begin
    for (int i = 0; i < pirb_pkg::ChanCount; i++) begin
      chan_en[i] = chan_row[i][0][7];
    end
  end

  assign stat_hit = (pointer >= pirb_pkg::StatFirst) && (pointer <= pirb_pkg::StatLast);
  assign en_sel   = ChanW'(pointer - pirb_pkg::StatLive);

  // read value at the pointer
  always_comb begin
    rd_value = 8'h00;
    priority if (stat_hit) begin
      if ((pointer >= pirb_pkg::StatLive) && chan_en[en_sel]) begin
        rd_value = pirb_pkg::LiveBits;
      end
    end else if (pointer == pirb_pkg::Reg00Addr) begin
      rd_value = pirb_pkg::Reg00Default;
    end else if (pointer == pirb_pkg::Reg01Addr) begin
      rd_value = pirb_pkg::Reg01Default;
    end else if (pointer == pirb_pkg::Reg02Addr) begin
      rd_value = reg02;
    end else if (pointer == pirb_pkg::Reg03Addr) begin
      rd_value = reg03;
    end else if (chan_hit) begin
      rd_value = chan_old;
    end else begin
      // unpopulated or out-of-bank address
      rd_value = 8'h00;
    end
  end

  assign result = (ev == pirb_pkg::MODE_READ) ? rd_value : 8'h00;

  // pointer, count and bank updates
  always_ff @(posedge clk) begin
    if (rst) begin
      pointer    <= 8'h00;
      byte_count <= 8'h00;
      reg02      <= pirb_pkg::Reg02Default;
      reg03      <= pirb_pkg::Reg03Default;
      for (int i = 0; i < pirb_pkg::ChanCount; i++) begin
        for (int j = 0; j < pirb_pkg::ChanRegs; j++) begin
          chan_row[i][j] <= pirb_pkg::ChanDefault[i][j];
        end
      end
    end else if (accept) begin
      unique case (ev)
        pirb_pkg::MODE_BOUNDARY: begin
          byte_count <= 8'h00;
        end
        pirb_pkg::MODE_WRITE: begin
          byte_count <= byte_count + 8'd1;
          if (byte_count == 8'h00) begin
            // first byte of a transfer is the register address
            pointer <= write_byte;
          end else begin
            if (pointer == pirb_pkg::Reg02Addr) begin
              reg02 <= (reg02 & ~pirb_pkg::Reg02Mask) | (write_byte & pirb_pkg::Reg02Mask);
            end else if (pointer == pirb_pkg::Reg03Addr) begin
              reg03 <= write_byte;
            end else if (chan_hit) begin
              chan_row[chan_sel][reg_sel] <= (chan_old & ~chan_m) | (write_byte & chan_m);
            end
            pointer <= pointer + 8'd1;
          end
        end
        pirb_pkg::MODE_READ: begin
          pointer <= pointer + 8'd1;
        end
        pirb_pkg::MODE_OTHER: begin
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_byte <= result;
    end
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the pmic i2c register bank
// ----------------------------------------------------------------------------
// a directed table walks reset defaults, masked writes, pointer wrap, status
// reads and the ignored event. After that come random bus transfers (write
// and read transfers with random content, plus some noise), with random idle
// gaps on both channels and long receiver stalls. A shadow copy of the bank
// predicts every read_byte, which is checked in order on the result channel.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StimItems = 1650;

  // one bus event, value is only used where fixed is set
  typedef struct packed {
    pirb_pkg::mode_t op;
    logic [7:0]      data;
    logic            fixed;
    logic [7:0]      value;
  } bus_event_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] mode;
  logic [7:0] write_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_byte;

  pmic_i2c_register_bank u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .write_byte (write_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_byte  (read_byte)
  );

  // shadow copy of the bank, pointer and byte count
  logic [7:0] shadow_bank [0:pirb_pkg::RegCount-1];
  logic [7:0] shadow_ptr;
  logic [7:0] shadow_count;

  bus_event_t stim_q[$];
  logic [7:0] read_byte_q[$];   // expected read_byte, oldest first
  int         stim_total;
  int         mismatches;
  int         results_seen;

  // channel register defaults: row is the output channel, column the low nibble
  localparam logic [7:0] ChanReset [6][6] = '{
    '{8'hf7, 8'hb7, 8'h37, 8'hf7, 8'h09, 8'hb0},
    '{8'heb, 8'hab, 8'hab, 8'heb, 8'h1d, 8'ha0},
    '{8'he3, 8'ha3, 8'h23, 8'he3, 8'h2c, 8'hb0},
    '{8'he3, 8'ha3, 8'h23, 8'he3, 8'h2c, 8'ha0},
    '{8'hb7, 8'hb7, 8'h37, 8'hb7, 8'h09, 8'ha0},
    '{8'h37, 8'h37, 8'h37, 8'h37, 8'h01, 8'ha0}
  };

  // directed events; value is typed in only where it is plain from the defaults
  localparam int DirectedRows = 23;
  bus_event_t directed_table [DirectedRows] = '{
    '{pirb_pkg::MODE_READ,     8'h00, 1'b1, 8'hdb},  // reset defaults, fixed registers
    '{pirb_pkg::MODE_READ,     8'h00, 1'b1, 8'h20},
    '{pirb_pkg::MODE_READ,     8'h00, 1'b1, 8'h54},
    '{pirb_pkg::MODE_READ,     8'h00, 1'b1, 8'hc0},
    '{pirb_pkg::MODE_READ,     8'h00, 1'b1, 8'h00},  // first status register, clear
    '{pirb_pkg::MODE_READ,     8'h00, 1'b0, 8'h00},  // status with live bits, channel one
    '{pirb_pkg::MODE_WRITE,    8'hff, 1'b1, 8'h00},  // pointer byte, top address
    '{pirb_pkg::MODE_WRITE,    8'ha5, 1'b1, 8'h00},  // beyond the bank: ignored, wraps
    '{pirb_pkg::MODE_READ,     8'h00, 1'b1, 8'hdb},  // read-only register after the wrap
    '{pirb_pkg::MODE_BOUNDARY, 8'h00, 1'b1, 8'h00},
    '{pirb_pkg::MODE_WRITE,    8'h02, 1'b1, 8'h00},
    '{pirb_pkg::MODE_WRITE,    8'hff, 1'b1, 8'h00},  // partially masked register
    '{pirb_pkg::MODE_WRITE,    8'h00, 1'b1, 8'h00},  // fully writable register
    '{pirb_pkg::MODE_BOUNDARY, 8'h00, 1'b1, 8'h00},
    '{pirb_pkg::MODE_WRITE,    8'h02, 1'b1, 8'h00},
    '{pirb_pkg::MODE_BOUNDARY, 8'h00, 1'b1, 8'h00},  // stop keeps the pointer
    '{pirb_pkg::MODE_READ,     8'h00, 1'b0, 8'h00},
    '{pirb_pkg::MODE_OTHER,    8'hff, 1'b1, 8'h00},
    '{pirb_pkg::MODE_WRITE,    8'h10, 1'b1, 8'h00},
    '{pirb_pkg::MODE_WRITE,    8'h00, 1'b1, 8'h00},  // drop the enable of channel one
    '{pirb_pkg::MODE_BOUNDARY, 8'h00, 1'b1, 8'h00},
    '{pirb_pkg::MODE_WRITE,    8'h05, 1'b1, 8'h00},
    '{pirb_pkg::MODE_READ,     8'h00, 1'b0, 8'h00}   // status without live bits now
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #2_000_000;
    $display("pmic_i2c_register_bank: mismatch");
    $finish;
  end

  task automatic load_default_bank();
    for (int a = 0; a < pirb_pkg::RegCount; a++) begin
      shadow_bank[a] = 8'h00;
    end
    shadow_bank[0] = 8'hdb;
    shadow_bank[1] = 8'h20;
    shadow_bank[2] = 8'h54;
    shadow_bank[3] = 8'hc0;
    for (int c = 0; c < 6; c++) begin
      for (int r = 0; r < 6; r++) begin
        shadow_bank[(c + 1) * 16 + r] = ChanReset[c][r];
      end
    end
    shadow_ptr   = 8'h00;
    shadow_count = 8'h00;
  endtask

  // which bits of a register a written byte may change
  function automatic logic [7:0] write_mask(input logic [7:0] addr);
    logic [7:0] m;
    m = 8'h00;
    if (addr == pirb_pkg::Reg02Addr) begin
      m = 8'hf7;
    end else if (addr == pirb_pkg::Reg03Addr) begin
      m = 8'hff;
    end else if (addr >= 8'h10 && addr <= 8'h45 && addr[3:0] <= 4'd5) begin
      m = 8'hff;
    end else if ((addr >= 8'h50 && addr <= 8'h55) || (addr >= 8'h60 && addr <= 8'h65)) begin
      if (addr[3:0] <= 4'd3) begin
        m = 8'hbf;
      end else if (addr[3:0] == 4'd4) begin
        m = 8'hff;
      end else begin
        m = 8'haf;
      end
    end
    return m;
  endfunction

  // advance the shadow bank by one event and give the byte it returns
  function automatic logic [7:0] predict_read_byte(input pirb_pkg::mode_t op,
                                                   input logic [7:0] data);
    logic [7:0] result;
    logic [7:0] m;
    logic [7:0] sticky;
    logic [7:0] chan;
    result = 8'h00;
    case (op)
      pirb_pkg::MODE_BOUNDARY: begin
        shadow_count = 8'h00;
      end
      pirb_pkg::MODE_WRITE: begin
        if (shadow_count == 8'h00) begin
          shadow_ptr = data;
        end else begin
          m = write_mask(shadow_ptr);
          if (shadow_ptr < pirb_pkg::RegCount && m != 8'h00) begin
            shadow_bank[shadow_ptr] = (shadow_bank[shadow_ptr] & ~m) | (data & m);
          end
          shadow_ptr = shadow_ptr + 8'd1;
        end
        shadow_count = shadow_count + 8'd1;
      end
      pirb_pkg::MODE_READ: begin
        if (shadow_ptr < pirb_pkg::RegCount) begin
          result = shadow_bank[shadow_ptr];
        end
        if (shadow_ptr >= pirb_pkg::StatFirst && shadow_ptr <= pirb_pkg::StatLast) begin
          // live bits follow the enable bit of the matching output channel
          if (shadow_ptr >= pirb_pkg::StatLive) begin
            chan = {shadow_ptr[3:0] - 4'd4, 4'h0};
            if (shadow_bank[chan][7]) begin
              result = result | pirb_pkg::LiveBits;
            end
          end
          if (shadow_ptr == pirb_pkg::StatFirst) begin
            sticky = 8'he0;
          end else if (shadow_ptr <= 8'h08) begin
            sticky = 8'hf0;
          end else begin
            sticky = 8'h80;
          end
          shadow_bank[shadow_ptr] = shadow_bank[shadow_ptr] & ~sticky;
        end
        shadow_ptr = shadow_ptr + 8'd1;
      end
      default: begin
      end
    endcase
    return result;
  endfunction

  task automatic add_event(input pirb_pkg::mode_t op, input logic [7:0] data);
    bus_event_t ev;
    ev.op    = op;
    ev.data  = data;
    ev.fixed = 1'b0;
    ev.value = 8'h00;
    stim_q.push_back(ev);
    // ignored events do not count towards the stimulus length
    if (op != pirb_pkg::MODE_OTHER) begin
      stim_total++;
    end
  endtask

  // register addresses, biased towards the populated parts of the map
  function automatic logic [7:0] pick_address();
    logic [7:0] addr;
    case ($urandom_range(0, 3))
      0: addr = 8'($urandom_range(0, 11));
      1: addr = {4'($urandom_range(1, 6)), 4'($urandom_range(0, 5))};
      2: addr = {4'($urandom_range(1, 6)), 4'($urandom)};
      default: addr = 8'($urandom);
    endcase
    return addr;
  endfunction

  task automatic build_random_transfers();
    int  kind;
    int  len;
    bit  long_done;
    long_done = 1'b0;
    while (stim_total < StimItems) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 6);
      if (!long_done && stim_total >= 800) begin
        // one write transfer long enough for the byte count to wrap,
        // so a late byte loads the pointer again
        long_done = 1'b1;
        add_event(pirb_pkg::MODE_BOUNDARY, 8'($urandom));
        add_event(pirb_pkg::MODE_WRITE, pick_address());
        for (int i = 0; i < 259; i++) begin
          add_event(pirb_pkg::MODE_WRITE, 8'($urandom));
        end
        add_event(pirb_pkg::MODE_BOUNDARY, 8'($urandom));
      end else if (kind <= 3) begin
        // write transfer: pointer byte then data bytes
        add_event(pirb_pkg::MODE_BOUNDARY, 8'($urandom));
        add_event(pirb_pkg::MODE_WRITE, pick_address());
        for (int i = 0; i < len; i++) begin
          add_event(pirb_pkg::MODE_WRITE, 8'($urandom));
        end
        add_event(pirb_pkg::MODE_BOUNDARY, 8'($urandom));
      end else if (kind <= 6) begin
        // read transfer: set the pointer, repeated start, read on
        add_event(pirb_pkg::MODE_BOUNDARY, 8'($urandom));
        add_event(pirb_pkg::MODE_WRITE, pick_address());
        add_event(pirb_pkg::MODE_BOUNDARY, 8'($urandom));
        for (int i = 0; i < len; i++) begin
          add_event(pirb_pkg::MODE_READ, 8'($urandom));
        end
        add_event(pirb_pkg::MODE_BOUNDARY, 8'($urandom));
      end else if (kind == 7) begin
        // reads carrying on from wherever the pointer stands
        for (int i = 0; i < len; i++) begin
          add_event(pirb_pkg::MODE_READ, 8'($urandom));
        end
      end else if (kind == 8) begin
        // broken transfer: no boundary before the bytes
        add_event(pirb_pkg::MODE_WRITE, pick_address());
        for (int i = 0; i < len; i++) begin
          add_event(($urandom_range(0, 1) == 0) ? pirb_pkg::MODE_READ : pirb_pkg::MODE_WRITE,
                    8'($urandom));
        end
      end else begin
        for (int i = 0; i < len; i++) begin
          add_event(pirb_pkg::mode_t'($urandom_range(0, 3)), 8'($urandom));
        end
      end
    end
  endtask

  // stimulus side: reset, then every event offered in order with random gaps
  initial begin : event_source
    bus_event_t ev;
    int         pause;
    bit         src_calm;
    logic [7:0] predicted;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    mode       <= pirb_pkg::MODE_OTHER;
    write_byte <= 8'h00;
    stim_total  = 0;
    mismatches  = 0;
    src_calm    = 1'b0;
    load_default_bank();
    for (int i = 0; i < DirectedRows; i++) begin
      stim_q.push_back(directed_table[i]);
      if (directed_table[i].op != pirb_pkg::MODE_OTHER) begin
        stim_total++;
      end
    end
    build_random_transfers();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_q[i]) begin
      ev = stim_q[i];
      // stretches with no gaps at all come and go
      if ($urandom_range(0, 39) == 0) begin
        src_calm = !src_calm;
      end
      pause = src_calm ? 0 : $urandom_range(0, 7);
      if (pause != 0) begin
        in_valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      in_valid   <= 1'b1;
      mode       <= ev.op;
      write_byte <= ev.data;
      @(posedge clk);
      while (in_ready !== 1'b1) @(posedge clk);
      // transfer accepted at this edge
      predicted = predict_read_byte(ev.op, ev.data);
      read_byte_q.push_back(ev.fixed ? ev.value : predicted);
    end
    in_valid <= 1'b0;

    // drain outstanding results, then give stray results a chance to show
    while (read_byte_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("pmic_i2c_register_bank: match");
    end else begin
      $display("pmic_i2c_register_bank: mismatch");
    end
    $finish;
  end

  // result side: random ready gaps, two long stalls to back the block up
  initial begin : result_sink
    int         pause;
    bit         sink_calm;
    logic [7:0] want;
    out_ready   <= 1'b0;
    sink_calm    = 1'b0;
    results_seen = 0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        sink_calm = !sink_calm;
      end
      pause = sink_calm ? 0 : $urandom_range(0, 7);
      // long hold-off while the source keeps offering transfers
      if (results_seen == 300 || results_seen == 1100) begin
        pause = 400;
      end
      if (pause != 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      // result transfer at this edge
      if (read_byte_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result 0x%02h with nothing expected", $realtime, read_byte);
        end
      end else begin
        want = read_byte_q.pop_front();
        if (read_byte !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: read_byte expected 0x%02h got 0x%02h", $realtime, want, read_byte);
          end
        end
      end
      results_seen++;
    end
  end

endmodule
